/* design/rht_pkg.sv */
// Package for the region hash table: table geometry, operation and status
// codes, and the home slot hash. No dependencies.
`default_nettype none
package rht_pkg;
   localparam int TableDepth = 256;
   localparam int SlotBits = $clog2(TableDepth);
   localparam int CountBits = $clog2(TableDepth + 1);
   localparam int KeyBits = 52;
   localparam int ByteBits = 48;
   localparam int EntryBits = KeyBits + 2 * ByteBits;

   typedef logic [SlotBits-1:0] slot_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [KeyBits-1:0] key_type;
   typedef logic [ByteBits-1:0] bytes_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL = 2'd2,
      ST_ZERO_KEY = 2'd3
   } status_type;

   typedef struct packed {
      key_type key;
      bytes_type size;
      bytes_type guard;
   } entry_type;

   // Hash folded to 64 bits, then reduced modulo the depth.
   function automatic slot_type home_slot(key_type u);
      logic [63:0] h;
      logic [63:0] w;
      begin
         w = {12'd0, u};
         h = w;
         h = (h << 7) - h + (w >> 16);
         h = (h << 7) - h + (w >> 32);
         h = (h << 7) - h + (w >> 48);
         home_slot = slot_type'(h % 64'(TableDepth));
      end
   endfunction

   function automatic slot_type step_down(slot_type i);
      begin
         step_down = (i == '0) ? slot_type'(TableDepth - 1) : slot_type'(i - 1'b1);
      end
   endfunction
endpackage
`default_nettype wire

/* design/rht_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on rht_pkg for the field widths.
`default_nettype none
interface rht_req_if;
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic [rht_pkg::KeyBits-1:0] page_key;
   logic [rht_pkg::ByteBits-1:0] region_size;
   logic [rht_pkg::ByteBits-1:0] guard_bytes;
   modport source (output valid, req_type, page_key, region_size, guard_bytes, input ready);
   modport sink (input valid, req_type, page_key, region_size, guard_bytes, output ready);
endinterface

interface rht_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [rht_pkg::ByteBits-1:0] found_size;
   logic [rht_pkg::ByteBits-1:0] found_guard;
   modport source (output valid, status, found_size, found_guard, input ready);
   modport sink (input valid, status, found_size, found_guard, output ready);
endinterface
`default_nettype wire

/* design/region_hash_table_top.sv */
// Region hash table top: sequencer around one slot memory. An accepted word is hashed, then
// each probed slot is read and checked in turn; zero key and full words skip to the response.
// Remove then shifts entries back: each slot scanned is read, hashed and checked, a moved entry
// also clears its old slot, and an empty slot ends the scan. One word at a time; the next is
// accepted the cycle after the response is taken. After reset a clearing pass empties every
// slot and no word is accepted meanwhile. Depends on rht_pkg, rht_if and rht_ram.
`default_nettype none
module region_hash_table_top (
   input wire logic clock,
   input wire logic reset,
   rht_req_if.sink req,
   rht_rsp_if.source rsp
);
   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE = 10'b0000000010,
      S_RD = 10'b0000000100,
      S_CHK = 10'b0000001000,
      S_SRD = 10'b0000010000,
      S_SCHK = 10'b0000100000,
      S_OUT = 10'b0001000000,
      S_HASH = 10'b0010000000,
      S_SHASH = 10'b0100000000,
      S_SCLR = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   rht_pkg::slot_type addr_ff, addr_in, hole_ff, hole_in;
   rht_pkg::count_type steps_ff, steps_in, free_ff, free_in;
   rht_pkg::op_type op_ff, op_in;
   rht_pkg::key_type key_ff, key_in;
   rht_pkg::bytes_type size_ff, size_in, guard_ff, guard_in;
   rht_pkg::status_type status_ff, status_in;
   rht_pkg::bytes_type fsize_ff, fsize_in, fguard_ff, fguard_in;
   rht_pkg::slot_type home_ff, home_in;
   rht_pkg::entry_type ent_ff, ent_in;
   logic wr_en;
   rht_pkg::slot_type ram_addr;
   rht_pkg::entry_type wr_data, rd_data;

   rht_ram u_ram (.clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_data),
      .rd_data(rd_data));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.status = status_ff;
   assign rsp.found_size = fsize_ff;
   assign rsp.found_guard = fguard_ff;

   always_comb begin
      logic between;
      state_in = state_ff; addr_in = addr_ff; hole_in = hole_ff; steps_in = steps_ff;
      free_in = free_ff; op_in = op_ff; key_in = key_ff; size_in = size_ff;
      guard_in = guard_ff; status_in = status_ff; fsize_in = fsize_ff;
      fguard_in = fguard_ff; home_in = home_ff; ent_in = ent_ff;
      wr_en = 1'b0; ram_addr = addr_ff; wr_data = '0;
      between = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == rht_pkg::slot_type'(rht_pkg::TableDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in = rht_pkg::op_type'(req.req_type);
               key_in = req.page_key;
               size_in = req.region_size;
               guard_in = req.guard_bytes;
               fsize_in = '0;
               fguard_in = '0;
               steps_in = '0;
               if (req.page_key == '0) begin
                  status_in = rht_pkg::ST_ZERO_KEY;
                  state_in = S_OUT;
               end else if (req.req_type == rht_pkg::OP_INSERT &&
                            ({2'b0, free_ff} << 2) <
                            (rht_pkg::CountBits + 2)'(rht_pkg::TableDepth)) begin
                  status_in = rht_pkg::ST_FULL;
                  state_in = S_OUT;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            addr_in = rht_pkg::home_slot(key_ff);
            state_in = S_RD;
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            state_in = S_RD;
            addr_in = rht_pkg::step_down(addr_ff);
            steps_in = steps_ff + 1'b1;
            if (op_ff == rht_pkg::OP_INSERT) begin
               if (rd_data.key == '0) begin
                  wr_en = 1'b1;
                  wr_data = '{key: key_ff, size: size_ff, guard: guard_ff};
                  if (free_ff != '0) free_in = free_ff - 1'b1;
                  status_in = rht_pkg::ST_OK;
                  state_in = S_OUT;
               end
            end else if (rd_data.key == key_ff) begin
               fsize_in = rd_data.size;
               fguard_in = rd_data.guard;
               status_in = rht_pkg::ST_OK;
               state_in = S_OUT;
               if (op_ff == rht_pkg::OP_UPDATE) begin
                  wr_en = 1'b1;
                  wr_data = '{key: rd_data.key, size: size_ff, guard: rd_data.guard};
               end else if (op_ff == rht_pkg::OP_REMOVE) begin
                  wr_en = 1'b1;
                  free_in = free_ff + 1'b1;
                  hole_in = addr_ff;
                  steps_in = '0;
                  state_in = S_SRD;
               end
            end else if (rd_data.key == '0) begin
               status_in = rht_pkg::ST_MISSING;
               state_in = S_OUT;
            end
            if (state_in == S_RD && steps_ff == rht_pkg::count_type'(rht_pkg::TableDepth - 1)) begin
               status_in = (op_ff == rht_pkg::OP_INSERT) ? rht_pkg::ST_FULL : rht_pkg::ST_MISSING;
               state_in = S_OUT;
            end
            if (state_in == S_SRD) addr_in = rht_pkg::step_down(addr_ff);
         end
         S_SRD: begin
            if (steps_ff == rht_pkg::count_type'(rht_pkg::TableDepth)) begin
               state_in = S_OUT;
            end else begin
               steps_in = steps_ff + 1'b1;
               state_in = S_SHASH;
            end
         end
         S_SHASH: begin
            ent_in = rd_data;
            home_in = rht_pkg::home_slot(rd_data.key);
            state_in = (rd_data.key == '0) ? S_OUT : S_SCHK;
         end
         S_SCHK: begin
            between = (addr_ff <= home_ff && home_ff < hole_ff) ||
                      (home_ff < hole_ff && hole_ff < addr_ff) ||
                      (hole_ff < addr_ff && addr_ff <= home_ff);
            if (between) begin
               addr_in = rht_pkg::step_down(addr_ff);
            end else begin
               wr_en = 1'b1;
               ram_addr = hole_ff;
               wr_data = ent_ff;
               hole_in = addr_ff;
               addr_in = addr_ff;
               state_in = S_SCLR;
            end
            if (between) state_in = S_SRD;
         end
         S_SCLR: begin
            wr_en = 1'b1;
            addr_in = rht_pkg::step_down(addr_ff);
            state_in = S_SRD;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         free_ff <= rht_pkg::count_type'(rht_pkg::TableDepth);
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         free_ff <= free_in;
      end
      hole_ff <= hole_in; steps_ff <= steps_in; op_ff <= op_in; key_ff <= key_in;
      size_ff <= size_in; guard_ff <= guard_in; status_ff <= status_in;
      fsize_ff <= fsize_in; fguard_ff <= fguard_in; home_ff <= home_in; ent_ff <= ent_in;
   end
endmodule
`default_nettype wire

/* design/rht_ram.sv */
// Single port synchronous slot memory with a registered read.
// Depends on rht_pkg for the entry type and depth.
`default_nettype none
module rht_ram (
   input wire logic clock,
   input wire logic wr_en,
   input wire rht_pkg::slot_type addr,
   input wire rht_pkg::entry_type wr_data,
   output rht_pkg::entry_type rd_data
);
   rht_pkg::entry_type mem [rht_pkg::TableDepth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* sim/rht_checker.sv */
// Checker for the region hash table: watches both channels, predicts each
// response word with its own table copy, and counts mismatches.
// Depends on rht_pkg and rht_if.
module rht_checker (
   input wire logic clock,
   input wire logic reset,
   rht_req_if.sink req,
   rht_rsp_if.sink rsp,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      rht_pkg::status_type status;
      rht_pkg::bytes_type size;
      rht_pkg::bytes_type guard;
   } answer_type;

   rht_pkg::key_type table_keys[rht_pkg::TableDepth];
   rht_pkg::bytes_type table_sizes[rht_pkg::TableDepth];
   rht_pkg::bytes_type table_guards[rht_pkg::TableDepth];
   int free_count;
   answer_type answers[$];

   function automatic int hash_slot(rht_pkg::key_type u);
      logic [63:0] h;
      logic [63:0] w;
      begin
         w = 64'(u);
         h = w;
         h = h * 64'd127 + (w >> 16);
         h = h * 64'd127 + (w >> 32);
         h = h * 64'd127 + (w >> 48);
         return int'(h % 64'(rht_pkg::TableDepth));
      end
   endfunction

   function automatic int slot_below(int i);
      return (i == 0) ? rht_pkg::TableDepth - 1 : i - 1;
   endfunction

   function automatic int locate(rht_pkg::key_type key);
      int i;
      begin
         i = hash_slot(key);
         for (int n = 0; n < rht_pkg::TableDepth; n++) begin
            if (table_keys[i] == key) return i;
            if (table_keys[i] == '0) return -1;
            i = slot_below(i);
         end
         return -1;
      end
   endfunction

   task automatic shift_back(int hole);
      int steps;
      int i;
      int j;
      int r;
      bit moved;
      begin
         steps = 0;
         i = hole;
         free_count++;
         forever begin
            j = i;
            moved = 0;
            table_keys[i] = '0;
            table_sizes[i] = '0;
            table_guards[i] = '0;
            while (steps < rht_pkg::TableDepth) begin
               steps++;
               i = slot_below(i);
               if (table_keys[i] == '0) return;
               r = hash_slot(table_keys[i]);
               if ((i <= r && r < j) || (r < j && j < i) || (j < i && i <= r)) continue;
               table_keys[j] = table_keys[i];
               table_sizes[j] = table_sizes[i];
               table_guards[j] = table_guards[i];
               moved = 1;
               break;
            end
            if (!moved) return;
         end
      end
   endtask

   task automatic predict_word(rht_pkg::op_type op, rht_pkg::key_type key,
         rht_pkg::bytes_type size, rht_pkg::bytes_type guard);
      answer_type a;
      int i;
      begin
         a = '{rht_pkg::ST_OK, '0, '0};
         if (key == '0) begin
            a.status = rht_pkg::ST_ZERO_KEY;
         end else if (op == rht_pkg::OP_INSERT) begin
            a.status = rht_pkg::ST_FULL;
            if (free_count * 4 >= rht_pkg::TableDepth) begin
               i = hash_slot(key);
               for (int n = 0; n < rht_pkg::TableDepth; n++) begin
                  if (table_keys[i] == '0) begin
                     table_keys[i] = key;
                     table_sizes[i] = size;
                     table_guards[i] = guard;
                     if (free_count > 0) free_count--;
                     a.status = rht_pkg::ST_OK;
                     break;
                  end
                  i = slot_below(i);
               end
            end
         end else begin
            i = locate(key);
            if (i < 0) begin
               a.status = rht_pkg::ST_MISSING;
            end else begin
               a.size = table_sizes[i];
               a.guard = table_guards[i];
               if (op == rht_pkg::OP_REMOVE) shift_back(i);
               else if (op == rht_pkg::OP_UPDATE) table_sizes[i] = size;
            end
         end
         answers.push_back(a);
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      begin
         $display("Mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int i = 0; i < rht_pkg::TableDepth; i++) begin
         table_keys[i] = '0;
         table_sizes[i] = '0;
         table_guards[i] = '0;
      end
      free_count = rht_pkg::TableDepth;
   end

   always @(posedge clock) begin
      answer_type a;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (answers.size() == 0) begin
               report("unexpected word", 64'(rsp.status), 64'd0);
            end else begin
               a = answers.pop_front();
               if (rsp.status !== a.status) report("status", 64'(rsp.status), 64'(a.status));
               if (rsp.found_size !== a.size) report("found_size", 64'(rsp.found_size), 64'(a.size));
               if (rsp.found_guard !== a.guard)
                  report("found_guard", 64'(rsp.found_guard), 64'(a.guard));
            end
         end
         if (req.valid && req.ready)
            predict_word(rht_pkg::op_type'(req.req_type), req.page_key, req.region_size,
               req.guard_bytes);
      end
      pending_count = answers.size();
   end
endmodule

/* sim/tb.sv */
// Testbench top for the region hash table: drives request words with random
// gaps and response stalls, and gives the verdict. Depends on rht_pkg, rht_if,
// rht_checker and the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int pending_count;
   int stall_left;
   int sent_count;
   rht_pkg::key_type used_keys[$];

   rht_req_if req ();
   rht_rsp_if rsp ();

   region_hash_table_top uut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));
   rht_checker checker_i (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.sink),
      .fail_count(fail_count), .pending_count(pending_count));

   always #10 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.req_type = '0;
      req.page_key = '0;
      req.region_size = '0;
      req.guard_bytes = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if ((rsp.valid && rsp.ready) || (!rsp.ready && stall_left == 0)) begin
         if (rsp.valid && rsp.ready) begin
            draw = $urandom_range(0, 7);
            if (draw == 0) begin
               rsp.ready <= 1'b1;
            end else begin
               stall_left <= draw - 1;
               rsp.ready <= 1'b0;
            end
         end else begin
            rsp.ready <= 1'b1;
         end
      end else if (!rsp.ready) begin
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_word(rht_pkg::op_type op, rht_pkg::key_type key,
         rht_pkg::bytes_type size, rht_pkg::bytes_type guard, bit gaps);
      int gap;
      begin
         gap = gaps ? $urandom_range(0, 7) : 0;
         repeat (gap) @(posedge clock);
         req.valid <= 1'b1;
         req.req_type <= op;
         req.page_key <= key;
         req.region_size <= size;
         req.guard_bytes <= guard;
         do @(posedge clock); while (!req.ready);
         req.valid <= 1'b0;
         sent_count++;
         if (op == rht_pkg::OP_INSERT && key != '0) used_keys.push_back(key);
      end
   endtask

   function automatic rht_pkg::key_type random_key();
      return rht_pkg::key_type'({$urandom(), $urandom()});
   endfunction

   function automatic rht_pkg::bytes_type random_bytes();
      return rht_pkg::bytes_type'({$urandom(), $urandom()});
   endfunction

   function automatic rht_pkg::key_type pick_key();
      if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      if ($urandom_range(0, 15) == 0) return '0;
      if ($urandom_range(0, 3) == 0) return rht_pkg::key_type'($urandom_range(1, 600));
      return random_key();
   endfunction

   initial begin
      rht_pkg::key_type k;
      rht_pkg::op_type op;
      int fills;
      sent_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words: zero key, extremes, duplicates, misses and removal.
      send_word(rht_pkg::OP_INSERT, '0, '1, '1, 0);
      send_word(rht_pkg::OP_LOOKUP, '0, '0, '0, 0);
      send_word(rht_pkg::OP_REMOVE, '0, '0, '0, 0);
      send_word(rht_pkg::OP_UPDATE, '0, '1, '0, 0);
      send_word(rht_pkg::OP_LOOKUP, rht_pkg::key_type'(1), '0, '0, 0);
      send_word(rht_pkg::OP_INSERT, '1, '1, '1, 0);
      send_word(rht_pkg::OP_INSERT, rht_pkg::key_type'(1), '0, '0, 0);
      send_word(rht_pkg::OP_INSERT, rht_pkg::key_type'(1), rht_pkg::bytes_type'(5),
         rht_pkg::bytes_type'(6), 0);
      send_word(rht_pkg::OP_LOOKUP, '1, '0, '0, 0);
      send_word(rht_pkg::OP_UPDATE, rht_pkg::key_type'(1), '1, '0, 0);
      send_word(rht_pkg::OP_LOOKUP, rht_pkg::key_type'(1), '0, '0, 0);
      send_word(rht_pkg::OP_INSERT, rht_pkg::key_type'(257), rht_pkg::bytes_type'(7),
         rht_pkg::bytes_type'(8), 0);
      send_word(rht_pkg::OP_INSERT, rht_pkg::key_type'(513), rht_pkg::bytes_type'(9),
         rht_pkg::bytes_type'(10), 0);
      send_word(rht_pkg::OP_REMOVE, rht_pkg::key_type'(1), '0, '0, 0);
      send_word(rht_pkg::OP_LOOKUP, rht_pkg::key_type'(1), '0, '0, 0);
      send_word(rht_pkg::OP_LOOKUP, rht_pkg::key_type'(513), '0, '0, 0);
      send_word(rht_pkg::OP_REMOVE, '1, '0, '0, 0);
      send_word(rht_pkg::OP_REMOVE, '1, '0, '0, 0);
      send_word(rht_pkg::OP_UPDATE, rht_pkg::key_type'(99), '1, '1, 0);

      // Fill past the three-quarter mark to provoke full status, then drain.
      for (fills = 0; fills < 200; fills++)
         send_word(rht_pkg::OP_INSERT, random_key() | rht_pkg::key_type'(1), random_bytes(),
            random_bytes(), 1);

      @(negedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);

      while (used_keys.size() > 40) begin
         k = used_keys[$urandom_range(0, used_keys.size() - 1)];
         send_word(rht_pkg::OP_REMOVE, k, random_bytes(), random_bytes(), 1);
         foreach (used_keys[i]) if (used_keys[i] == k) begin
            used_keys.delete(i);
            break;
         end
      end

      for (int n = 0; n < 170; n++) begin
         op = rht_pkg::op_type'($urandom_range(0, 3));
         k = pick_key();
         send_word(op, k, random_bytes(), random_bytes(), $urandom_range(0, 3) != 0);
      end

      @(negedge clock);
      wait (pending_count == 0);
      repeat (300) @(posedge clock);
      $display("Sent %0d request words: directed extremes, a fill to the full mark,", sent_count);
      $display("a drain by remove, and random insert, lookup, remove and resize words.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
